/* rtl/obau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package obau_pkg;

  localparam int FRAC_BITS          = 16;
  localparam int NORMAL_TABLE_DEPTH = 1024;
  localparam int Q_SHIFT            = 30 - FRAC_BITS;
  localparam int TAB_BITS           = $clog2(NORMAL_TABLE_DEPTH);
  localparam int TAB_AW             = TAB_BITS + 1;
  localparam int FR_W               = 33 - TAB_BITS;

  localparam logic signed [63:0] Q30_ONE          = 64'sd1 <<< 30;
  localparam logic [63:0]        SAT_MAG          = (64'd1 << 62) - 64'd1;
  localparam logic [63:0]        LN2_Q30          = 64'd744261118;
  localparam logic [63:0]        INV_SQRT_2PI_Q30 = 64'd428361012;
  localparam logic [63:0]        TAB_DD  = 64'(NORMAL_TABLE_DEPTH) * 64'(NORMAL_TABLE_DEPTH);
  localparam logic [63:0]        TAB_DEN = 64'd3 * 64'(NORMAL_TABLE_DEPTH);

  typedef logic [30:0] tab_t [0:NORMAL_TABLE_DEPTH];

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } alu_stat_t;

  typedef enum logic {
    REG_PRIOR_MEAN = 1'b0,
    REG_PRIOR_VAR  = 1'b1
  } cfg_reg_e;

  // exp(-y), Q30 in and out
  function automatic logic [63:0] expneg(input logic [63:0] y);
    logic [63:0]        n;
    logic [63:0]        r;
    logic [63:0]        term;
    logic signed [63:0] sum;
    n    = y / LN2_Q30;
    r    = y - n * LN2_Q30;
    sum  = Q30_ONE;
    term = 64'd1 << 30;
    if (n >= 64'd62) return 64'd0;
    for (int i = 1; i <= 13; i++) begin
      term = ((term * r) >> 30) / 64'(i);
      if (i[0]) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    return 64'(sum) >> n;
  endfunction

  // phi at j * 4 / depth
  function automatic logic [63:0] phi_half(input logic [63:0] j);
    logic [63:0] y;
    y = ((64'd8 * j * j) << 30) / TAB_DD;
    return (expneg(y) * INV_SQRT_2PI_Q30) >> 30;
  endfunction

  function automatic tab_t build_phi();
    tab_t t;
    for (int k = 0; k <= NORMAL_TABLE_DEPTH; k++) t[k] = 31'(phi_half(64'(2 * k)));
    return t;
  endfunction

  // upper tail by simpson integration from the far end
  function automatic tab_t build_tail();
    tab_t        ph;
    tab_t        t;
    logic [63:0] acc;
    logic [63:0] sum;
    ph  = build_phi();
    acc = 64'd0;
    t[NORMAL_TABLE_DEPTH] = 31'd0;
    for (int k = NORMAL_TABLE_DEPTH - 1; k >= 0; k--) begin
      sum = 64'(ph[k]) + 64'd4 * phi_half(64'(2 * k + 1)) + 64'(ph[k + 1]);
      acc = acc + (sum * 64'd4 + TAB_DEN / 64'd2) / TAB_DEN;
      if (acc > (64'd1 << 30)) acc = 64'd1 << 30;
      t[k] = 31'(acc);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

/* rtl/owen_bayesian_ability_update_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Owen sequential ability update for four-parameter items. Keeps a normal
// posterior (mean, variance) and updates it from one scored response per
// request; each request returns the mean, the variance and the standard error.
// Arithmetic runs in Q30 on one shared multiply / divide / square-root unit
// under a step sequencer; the normal density and tail come from constant
// tables read with linear interpolation. One request at a time: a full update
// runs six or seven divisions that retire one quotient bit per cycle, nine
// multiplies, two square roots, a normalize loop and a table lookup. A
// missing response runs only the standard-error square root, and an item
// with no information keeps the state. No clearing pass after reset.
module owen_bayesian_ability_update_core
  import obau_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // difficulty[31:0], discrimination[62:32], scaling[93:63],
  // lower_asymptote[110:94], upper_asymptote[127:111], response[128]
  input  logic [135:0] s_axis_tdata,
  // start_new[0], response_missing[1]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ability_mean[31:0], ability_variance[62:32], standard_error[93:63]
  output logic [95:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RUN  = 6'b000010,
    S_WAIT = 6'b000100,
    S_NORM = 6'b001000,
    S_LOOK = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  typedef enum logic [17:0] {
    ST_AE    = 18'h00001,
    ST_A2    = 18'h00002,
    ST_INVA2 = 18'h00004,
    ST_SQS   = 18'h00008,
    ST_Z     = 18'h00010,
    ST_AA    = 18'h00020,
    ST_W     = 18'h00040,
    ST_PDIV  = 18'h00080,
    ST_G     = 18'h00100,
    ST_IR    = 18'h00200,
    ST_M1A   = 18'h00400,
    ST_M1B   = 18'h00800,
    ST_IS    = 18'h01000,
    ST_V1A   = 18'h02000,
    ST_V1B   = 18'h04000,
    ST_V1C   = 18'h08000,
    ST_V1D   = 18'h10000,
    ST_SE    = 18'h20000
  } step_e;

  localparam tab_t PHI_ROM  = build_phi();
  localparam tab_t TAIL_ROM = build_tail();
  localparam logic [16:0] ONE_F = 17'd1 << FRAC_BITS;
  localparam logic [TAB_AW-1:0] LAST_IDX = TAB_AW'(NORMAL_TABLE_DEPTH);

  function automatic logic signed [63:0] sadd(input logic signed [63:0] x,
                                              input logic signed [63:0] y);
    logic signed [63:0] s;
    logic [63:0]        m;
    s = x + y;
    m = s[63] ? 64'(-s) : 64'(s);
    if (m > SAT_MAG) m = SAT_MAG;
    return s[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] rnd_back(input logic [63:0] m);
    return (m + (64'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
  endfunction

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic [1:0] lk_q, lk_d;
  logic [3:0] k_q, k_d;

  logic signed [31:0] prior_mean_q, prior_mean_d;
  logic [30:0]        prior_var_q, prior_var_d;
  logic signed [31:0] post_mean_q, post_mean_d;
  logic [30:0]        post_var_q, post_var_d;

  logic [30:0]        disc_q, disc_d;
  logic [30:0]        scal_q, scal_d;
  logic [16:0]        cf_q, cf_d;
  logic [16:0]        df_q, df_d;
  logic               resp_q, resp_d;
  logic signed [63:0] m0_q, m0_d, v0_q, v0_d, b_q, b_d;
  logic signed [63:0] t0_q, t0_d, t1_q, t1_d, s_q, s_d, r_q, r_d, z_q, z_d;
  logic signed [63:0] ph_q, ph_d, p_q, p_d, pm_q, pm_d, aa_q, aa_d;
  logic signed [63:0] w_q, w_d, g_q, g_d, m1_q, m1_d;
  logic [TAB_AW-1:0]  addr0_q, addr0_d, addr1_q, addr1_d;
  logic [FR_W-1:0]    fr_q, fr_d;
  logic [53:0]        prodp_q, prodp_d, prodt_q, prodt_d;
  logic               negp_q, negp_d, negt_q, negt_d;

  logic [30:0] phi0_q, phi1_q, tail0_q, tail1_q;

  logic               ovalid_q, ovalid_d;
  logic [31:0]        omean_q, omean_d;
  logic [30:0]        ovar_q, ovar_d;
  logic [30:0]        ose_q, ose_d;

  alu_req_t           alu_req;
  alu_stat_t          alu_stat;
  logic signed [63:0] alu_x, alu_y;

  logic               in_acc;
  logic signed [31:0] ld_mean;
  logic [30:0]        ld_var;
  logic signed [63:0] c30, d30, a30, sc30, res;
  logic signed [63:0] tmp, v1;
  logic [63:0]        az, mm, sm;
  logic [5:0]         nsh;
  logic signed [31:0] dph, dtl;
  logic [30:0]        dphm, dtlm;
  logic signed [63:0] phv, tqv, pv;

  obau_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .x_i    (alu_x),
    .y_i    (alu_y),
    .stat_o (alu_stat)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {2'b00, ose_q, ovar_q, omean_q};

  assign c30  = $signed(64'(cf_q) << Q_SHIFT);
  assign d30  = $signed(64'(df_q) << Q_SHIFT);
  assign a30  = $signed(64'(disc_q) << Q_SHIFT);
  assign sc30 = $signed(64'(scal_q) << Q_SHIFT);
  assign res  = alu_stat.res;

  // operand selection per step
  always_comb begin
    alu_req.start = (state_q == S_RUN);
    alu_req.op    = ALU_MUL;
    alu_x         = 64'sd0;
    alu_y         = 64'sd0;
    case (step_q)
      ST_AE:    begin alu_req.op = ALU_DIV;  alu_x = a30;     alu_y = sc30; end
      ST_A2:    begin alu_req.op = ALU_MUL;  alu_x = t0_q;    alu_y = t0_q; end
      ST_INVA2: begin alu_req.op = ALU_DIV;  alu_x = Q30_ONE; alu_y = t0_q; end
      ST_SQS: begin
        alu_req.op = ALU_SQRT;
        alu_x      = $signed(64'(s_q) << {k_q, 1'b0});
      end
      ST_Z:     begin alu_req.op = ALU_DIV;  alu_x = sadd(b_q, -m0_q); alu_y = r_q; end
      ST_AA:    begin alu_req.op = ALU_MUL;  alu_x = d30 - c30; alu_y = pm_q; end
      ST_W:     begin alu_req.op = ALU_DIV;  alu_x = Q30_ONE; alu_y = aa_q; end
      ST_PDIV:  begin alu_req.op = ALU_DIV;  alu_x = ph_q;    alu_y = p_q;  end
      ST_G:     begin alu_req.op = ALU_MUL;  alu_x = t0_q;    alu_y = w_q;  end
      ST_IR:    begin alu_req.op = ALU_DIV;  alu_x = Q30_ONE; alu_y = r_q;  end
      ST_M1A:   begin alu_req.op = ALU_MUL;  alu_x = v0_q;    alu_y = t0_q; end
      ST_M1B:   begin alu_req.op = ALU_MUL;  alu_x = t0_q;    alu_y = g_q;  end
      ST_IS:    begin alu_req.op = ALU_DIV;  alu_x = Q30_ONE; alu_y = s_q;  end
      ST_V1A:   begin alu_req.op = ALU_MUL;  alu_x = v0_q;    alu_y = t0_q; end
      ST_V1B:   begin alu_req.op = ALU_MUL;  alu_x = v0_q;    alu_y = t0_q; end
      ST_V1C:   begin alu_req.op = ALU_MUL;  alu_x = g_q;     alu_y = sadd(g_q, z_q); end
      ST_V1D:   begin alu_req.op = ALU_MUL;  alu_x = t0_q;    alu_y = t1_q; end
      ST_SE: begin
        alu_req.op = ALU_SQRT;
        alu_x      = $signed(64'(post_var_q) << FRAC_BITS);
      end
      default: begin
        alu_req.op = ALU_MUL;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    lk_d         = lk_q;
    k_d          = k_q;
    prior_mean_d = prior_mean_q;
    prior_var_d  = prior_var_q;
    post_mean_d  = post_mean_q;
    post_var_d   = post_var_q;
    disc_d       = disc_q;
    scal_d       = scal_q;
    cf_d         = cf_q;
    df_d         = df_q;
    resp_d       = resp_q;
    m0_d         = m0_q;
    v0_d         = v0_q;
    b_d          = b_q;
    t0_d         = t0_q;
    t1_d         = t1_q;
    s_d          = s_q;
    r_d          = r_q;
    z_d          = z_q;
    ph_d         = ph_q;
    p_d          = p_q;
    pm_d         = pm_q;
    aa_d         = aa_q;
    w_d          = w_q;
    g_d          = g_q;
    m1_d         = m1_q;
    addr0_d      = addr0_q;
    addr1_d      = addr1_q;
    fr_d         = fr_q;
    prodp_d      = prodp_q;
    prodt_d      = prodt_q;
    negp_d       = negp_q;
    negt_d       = negt_q;
    ovalid_d     = ovalid_q;
    omean_d      = omean_q;
    ovar_d       = ovar_q;
    ose_d        = ose_q;

    ld_mean = s_axis_tuser[0] ? prior_mean_q : post_mean_q;
    ld_var  = s_axis_tuser[0] ? prior_var_q : post_var_q;
    tmp     = sadd(res, v0_q);
    v1      = sadd(v0_q, -res);
    mm      = rnd_back(m1_q[63] ? 64'(-m1_q) : 64'(m1_q));
    sm      = rnd_back(64'(v1));
    nsh     = 6'd62 - {1'b0, k_q, 1'b0};
    az      = z_q[63] ? 64'(-z_q) : 64'(z_q);
    dph     = $signed({1'b0, phi1_q}) - $signed({1'b0, phi0_q});
    dtl     = $signed({1'b0, tail1_q}) - $signed({1'b0, tail0_q});
    dphm    = dph[31] ? 31'(-dph) : dph[30:0];
    dtlm    = dtl[31] ? 31'(-dtl) : dtl[30:0];
    phv     = negp_q ? $signed(64'(phi0_q)) - $signed(64'(prodp_q >> FR_W))
                     : $signed(64'(phi0_q)) + $signed(64'(prodp_q >> FR_W));
    tqv     = negt_q ? $signed(64'(tail0_q)) - $signed(64'(prodt_q >> FR_W))
                     : $signed(64'(tail0_q)) + $signed(64'(prodt_q >> FR_W));
    pv      = z_q[63] ? tqv : Q30_ONE - tqv;

    if (cfg_we_i) begin
      if (cfg_addr_i == REG_PRIOR_MEAN) prior_mean_d = $signed(cfg_wdata_i);
      else prior_var_d = cfg_wdata_i[30:0];
    end

    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          post_mean_d = ld_mean;
          post_var_d  = ld_var;
          m0_d   = $signed(64'(ld_mean)) <<< Q_SHIFT;
          v0_d   = $signed(64'(ld_var) << Q_SHIFT);
          b_d    = $signed(64'($signed(s_axis_tdata[31:0]))) <<< Q_SHIFT;
          disc_d = s_axis_tdata[62:32];
          scal_d = (s_axis_tdata[93:63] == 31'd0) ? 31'd1 : s_axis_tdata[93:63];
          cf_d   = (s_axis_tdata[110:94] > ONE_F) ? ONE_F : s_axis_tdata[110:94];
          df_d   = (s_axis_tdata[127:111] > ONE_F) ? ONE_F : s_axis_tdata[127:111];
          resp_d = s_axis_tdata[128];
          step_d  = s_axis_tuser[1] ? ST_SE : ST_AE;
          state_d = S_RUN;
        end
      end
      S_RUN: state_d = S_WAIT;
      S_WAIT: begin
        if (alu_stat.done) begin
          state_d = S_RUN;
          case (step_q)
            ST_AE: begin t0_d = res; step_d = ST_A2; end
            ST_A2: begin
              // no information carried: keep the state
              t0_d   = res;
              step_d = (res == 64'sd0) ? ST_SE : ST_INVA2;
            end
            ST_INVA2: begin
              s_d     = (tmp < 64'sd1) ? 64'sd1 : tmp;
              k_d     = 4'd15;
              step_d  = ST_SQS;
              state_d = S_NORM;
            end
            ST_SQS: begin
              r_d    = $signed(64'(res) << (4'd15 - k_q));
              step_d = ST_Z;
            end
            ST_Z: begin
              z_d     = res;
              lk_d    = 2'd0;
              step_d  = ST_AA;
              state_d = S_LOOK;
            end
            ST_AA: begin
              aa_d = ((c30 + res) < 64'sd1) ? 64'sd1 : c30 + res;
              w_d  = Q30_ONE;
              step_d = resp_q ? ST_W : ST_PDIV;
            end
            ST_W:    begin w_d  = Q30_ONE - res; step_d = ST_PDIV; end
            ST_PDIV: begin t0_d = res; step_d = ST_G;   end
            ST_G:    begin g_d  = res; step_d = ST_IR;  end
            ST_IR:   begin t0_d = res; step_d = ST_M1A; end
            ST_M1A:  begin t0_d = res; step_d = ST_M1B; end
            ST_M1B:  begin m1_d = sadd(m0_q, -res); step_d = ST_IS; end
            ST_IS:   begin t0_d = res; step_d = ST_V1A; end
            ST_V1A:  begin t0_d = res; step_d = ST_V1B; end
            ST_V1B:  begin t0_d = res; step_d = ST_V1C; end
            ST_V1C:  begin t1_d = res; step_d = ST_V1D; end
            ST_V1D: begin
              if (m1_q[63]) begin
                post_mean_d = (mm > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-mm);
              end else begin
                post_mean_d = (mm > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(mm);
              end
              if (v1[63]) post_var_d = 31'd0;
              else post_var_d = (sm > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(sm);
              step_d = ST_SE;
            end
            ST_SE: begin
              // held apart from the output register, which may still be busy
              t1_d    = res;
              state_d = S_OUT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_NORM: begin
        // largest k with s below 2^(62-2k)
        if ((k_q != 4'd0) && ((64'(s_q) >> nsh) != 64'd0)) k_d = k_q - 4'd1;
        else state_d = S_RUN;
      end
      S_LOOK: begin
        lk_d = lk_q + 2'd1;
        case (lk_q)
          2'd0: begin
            if (az[63:33] != 31'd0) begin
              addr0_d = LAST_IDX;
              addr1_d = LAST_IDX;
              fr_d    = '0;
            end else begin
              addr0_d = {1'b0, az[32:FR_W]};
              addr1_d = {1'b0, az[32:FR_W]} + TAB_AW'(1);
              fr_d    = az[FR_W-1:0];
            end
          end
          2'd1: ;
          2'd2: begin
            prodp_d = 54'(dphm) * 54'(fr_q);
            prodt_d = 54'(dtlm) * 54'(fr_q);
            negp_d  = dph[31];
            negt_d  = dtl[31];
          end
          default: begin
            ph_d    = phv;
            p_d     = (pv < 64'sd1) ? 64'sd1 : pv;
            pm_d    = z_q[63] ? Q30_ONE - tqv : tqv;
            state_d = S_RUN;
          end
        endcase
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          omean_d  = post_mean_q;
          ovar_d   = post_var_q;
          ose_d    = 31'(t1_q);
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= ST_SE;
      lk_q         <= 2'd0;
      k_q          <= 4'd0;
      prior_mean_q <= 32'sd0;
      prior_var_q  <= 31'(1) << FRAC_BITS;
      post_mean_q  <= 32'sd0;
      post_var_q   <= 31'(1) << FRAC_BITS;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      lk_q         <= lk_d;
      k_q          <= k_d;
      prior_mean_q <= prior_mean_d;
      prior_var_q  <= prior_var_d;
      post_mean_q  <= post_mean_d;
      post_var_q   <= post_var_d;
      ovalid_q     <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    disc_q  <= disc_d;
    scal_q  <= scal_d;
    cf_q    <= cf_d;
    df_q    <= df_d;
    resp_q  <= resp_d;
    m0_q    <= m0_d;
    v0_q    <= v0_d;
    b_q     <= b_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    s_q     <= s_d;
    r_q     <= r_d;
    z_q     <= z_d;
    ph_q    <= ph_d;
    p_q     <= p_d;
    pm_q    <= pm_d;
    aa_q    <= aa_d;
    w_q     <= w_d;
    g_q     <= g_d;
    m1_q    <= m1_d;
    addr0_q <= addr0_d;
    addr1_q <= addr1_d;
    fr_q    <= fr_d;
    prodp_q <= prodp_d;
    prodt_q <= prodt_d;
    negp_q  <= negp_d;
    negt_q  <= negt_d;
    omean_q <= omean_d;
    ovar_q  <= ovar_d;
    ose_q   <= ose_d;
  end

  // density and tail tables, registered reads
  always_ff @(posedge clk_i) begin
    phi0_q  <= PHI_ROM[addr0_q];
    phi1_q  <= PHI_ROM[addr1_q];
    tail0_q <= TAIL_ROM[addr0_q];
    tail1_q <= TAIL_ROM[addr1_q];
  end

endmodule
`default_nettype wire

/* rtl/obau_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
module obau_alu
  import obau_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alu_req_t           req_i,
  input  logic signed [63:0] x_i,
  input  logic signed [63:0] y_i,
  output alu_stat_t          stat_o
);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_SQRT = 4'b1000
  } alu_state_e;

  alu_state_e         state_q, state_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [63:0]        opa_q, opa_d;
  logic [63:0]        opb_q, opb_d;
  logic               neg_q, neg_d;
  logic [63:0]        pp_q, pp_d;
  logic [1:0]         ppsh_q, ppsh_d;
  logic               ppv_q, ppv_d;
  logic [127:0]       acc_q, acc_d;
  logic [63:0]        rem_q, rem_d;
  logic [61:0]        dq_q, dq_d;
  logic [63:0]        rq_q, rq_d;
  logic [63:0]        bit_q, bit_d;
  logic               done_q, done_d;
  logic signed [63:0] res_q, res_d;

  logic [63:0]  xm, ym, ay;
  logic [31:0]  ha, hb;
  logic [127:0] pp_sh;
  logic [64:0]  tdiv;
  logic         ge;
  logic [63:0]  tsq;
  logic [63:0]  mmag;
  logic [63:0]  qv;

  assign stat_o.done = done_q;
  assign stat_o.res  = res_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    neg_d   = neg_q;
    pp_d    = pp_q;
    ppsh_d  = ppsh_q;
    ppv_d   = 1'b0;
    acc_d   = acc_q;
    rem_d   = rem_q;
    dq_d    = dq_q;
    rq_d    = rq_q;
    bit_d   = bit_q;
    done_d  = 1'b0;
    res_d   = res_q;

    xm = x_i[63] ? 64'(-x_i) : 64'(x_i);
    ym = y_i[63] ? 64'(-y_i) : 64'(y_i);
    ay = (ym == 64'd0) ? 64'd1 : ym;

    ha    = cnt_q[1] ? opa_q[63:32] : opa_q[31:0];
    hb    = cnt_q[0] ? opb_q[63:32] : opb_q[31:0];
    case (ppsh_q)
      2'd0:    pp_sh = {64'd0, pp_q};
      2'd1:    pp_sh = {32'd0, pp_q, 32'd0};
      default: pp_sh = {pp_q, 64'd0};
    endcase
    // a full product past 64 bits saturates
    mmag = (acc_q[127:64] != 64'd0) ? SAT_MAG : {30'd0, acc_q[63:30]};

    tdiv = {rem_q, dq_q[61]};
    ge   = (tdiv >= {1'b0, opb_q});
    qv   = {2'b00, dq_q[60:0], ge};

    tsq = rq_q + bit_q;

    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          neg_d = x_i[63] ^ y_i[63];
          cnt_d = 7'd0;
          case (req_i.op)
            ALU_MUL: begin
              opa_d   = xm;
              opb_d   = ym;
              acc_d   = 128'd0;
              state_d = A_MUL;
            end
            ALU_DIV: begin
              opb_d = ay;
              if ({32'd0, xm} >= {ay, 32'd0}) begin
                // quotient does not fit, saturate
                res_d  = (x_i[63] ^ y_i[63]) ? -$signed(SAT_MAG) : $signed(SAT_MAG);
                done_d = 1'b1;
              end else begin
                rem_d   = {32'd0, xm[63:32]};
                dq_d    = {xm[31:0], 30'd0};
                state_d = A_DIV;
              end
            end
            ALU_SQRT: begin
              opa_d   = x_i;
              rq_d    = 64'd0;
              bit_d   = 64'd1 << 62;
              state_d = A_SQRT;
            end
            default: begin
              res_d  = 64'sd0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      A_MUL: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q < 7'd4) begin
          pp_d   = 64'(ha) * 64'(hb);
          ppsh_d = 2'(cnt_q[1]) + 2'(cnt_q[0]);
          ppv_d  = 1'b1;
        end
        if (ppv_q) acc_d = acc_q + pp_sh;
        if (cnt_q == 7'd5) begin
          res_d   = neg_q ? -$signed(mmag) : $signed(mmag);
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      A_DIV: begin
        cnt_d = cnt_q + 7'd1;
        rem_d = ge ? 64'(tdiv - {1'b0, opb_q}) : tdiv[63:0];
        dq_d  = {dq_q[60:0], ge};
        if (cnt_q == 7'd61) begin
          res_d   = neg_q ? -$signed(qv) : $signed(qv);
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      A_SQRT: begin
        cnt_d = cnt_q + 7'd1;
        bit_d = bit_q >> 2;
        if (opa_q >= tsq) begin
          opa_d = opa_q - tsq;
          rq_d  = (rq_q >> 1) + bit_q;
        end else begin
          rq_d = rq_q >> 1;
        end
        if (cnt_q == 7'd31) begin
          res_d   = $signed(rq_d);
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= 7'd0;
      ppv_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ppv_q   <= ppv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    neg_q  <= neg_d;
    pp_q   <= pp_d;
    ppsh_q <= ppsh_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    rq_q   <= rq_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
  end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import obau_pkg::*;

  typedef longint          s64;
  typedef longint unsigned u64;

  typedef struct {
    bit          start_new;
    bit          missing;
    logic [31:0] difficulty;
    logic [30:0] discrimination;
    logic [30:0] scaling;
    logic [16:0] lower_asym;
    logic [16:0] upper_asym;
    bit          response;
  } response_item_t;

  typedef struct {
    logic [31:0] mean;
    logic [30:0] variance;
    logic [30:0] std_err;
  } estimate_t;

  localparam s64 ONE_Q30 = 64'sd1 <<< 30;
  localparam u64 MAG_MAX = (64'd1 << 62) - 64'd1;

  class ability_scoreboard;
    u64          phi_q30[0:NORMAL_TABLE_DEPTH];
    u64          tail_q30[0:NORMAL_TABLE_DEPTH];
    logic [31:0] cfg_mean;
    logic [30:0] cfg_var;
    s64          post_mean;
    u64          post_var;
    estimate_t   expected_estimates[$];
    int          errors;

    function new();
      u64 acc;
      u64 sum;
      for (int k = 0; k <= NORMAL_TABLE_DEPTH; k++) phi_q30[k] = density_at(u64'(2 * k));
      tail_q30[NORMAL_TABLE_DEPTH] = 0;
      acc = 0;
      for (int k = NORMAL_TABLE_DEPTH - 1; k >= 0; k--) begin
        sum = phi_q30[k] + 64'd4 * density_at(u64'(2 * k + 1)) + phi_q30[k + 1];
        acc = acc + (sum * 64'd4 + (64'd3 * NORMAL_TABLE_DEPTH) / 2) /
              (64'd3 * NORMAL_TABLE_DEPTH);
        if (acc > u64'(ONE_Q30)) acc = u64'(ONE_Q30);
        tail_q30[k] = acc;
      end
      cfg_mean  = 32'd0;
      cfg_var   = 31'd65536;
      post_mean = 0;
      post_var  = 65536;
      errors    = 0;
    endfunction

    function u64 mag(s64 x);
      return x < 0 ? 64'd0 - u64'(x) : u64'(x);
    endfunction

    function s64 clip(u64 m, bit neg);
      if (m > MAG_MAX) m = MAG_MAX;
      return neg ? -s64'(m) : s64'(m);
    endfunction

    function s64 add_sat(s64 x, s64 y);
      s64 s;
      s = x + y;
      return clip(mag(s), s < 0);
    endfunction

    function s64 mul_q(s64 x, s64 y);
      u64 ax;
      u64 ay;
      bit neg;
      ax  = mag(x);
      ay  = mag(y);
      neg = (x < 0) != (y < 0);
      if (ax != 0 && ay > 64'hFFFF_FFFF_FFFF_FFFF / ax) return clip(64'hFFFF_FFFF_FFFF_FFFF, neg);
      return clip((ax * ay) >> 30, neg);
    endfunction

    function s64 div_q(s64 x, s64 y);
      u64 ax;
      u64 ay;
      u64 q;
      u64 r;
      bit neg;
      ax  = mag(x);
      ay  = mag(y);
      neg = (x < 0) != (y < 0);
      if (ay == 0) ay = 1;
      q = ax / ay;
      if (q >= (64'd1 << 32)) return clip(64'hFFFF_FFFF_FFFF_FFFF, neg);
      r = ax % ay;
      for (int i = 0; i < 30; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ay) begin
          r = r - ay;
          q = q | 64'd1;
        end
      end
      return clip(q, neg);
    endfunction

    function u64 int_sqrt(u64 x);
      u64 res;
      u64 b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x   = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function u64 exp_neg(u64 y);
      u64 n;
      u64 r;
      s64 sum;
      u64 term;
      n    = y / 64'd744261118;
      r    = y - n * 64'd744261118;
      sum  = ONE_Q30;
      term = u64'(ONE_Q30);
      if (n >= 62) return 0;
      for (int i = 1; i <= 13; i++) begin
        term = ((term * r) >> 30) / u64'(i);
        if (i % 2 == 1) sum = sum - s64'(term);
        else sum = sum + s64'(term);
      end
      return u64'(sum) >> n;
    endfunction

    // density at z = j * 4 / depth
    function u64 density_at(u64 j);
      u64 y;
      y = ((64'd8 * j * j) << 30) / (u64'(NORMAL_TABLE_DEPTH) * NORMAL_TABLE_DEPTH);
      return (exp_neg(y) * 64'd428361012) >> 30;
    endfunction

    function s64 interp(bit use_tail, u64 az);
      u64 pos;
      u64 k;
      u64 frac;
      s64 lo;
      s64 hi;
      if (az >= (64'd8 << 30)) begin
        return use_tail ? s64'(tail_q30[NORMAL_TABLE_DEPTH]) : s64'(phi_q30[NORMAL_TABLE_DEPTH]);
      end
      pos = az * NORMAL_TABLE_DEPTH;
      k   = pos >> 33;
      if (k >= NORMAL_TABLE_DEPTH) begin
        return use_tail ? s64'(tail_q30[NORMAL_TABLE_DEPTH]) : s64'(phi_q30[NORMAL_TABLE_DEPTH]);
      end
      frac = pos & ((64'd1 << 33) - 1);
      lo   = use_tail ? s64'(tail_q30[k]) : s64'(phi_q30[k]);
      hi   = use_tail ? s64'(tail_q30[k + 1]) : s64'(phi_q30[k + 1]);
      return lo + ((hi - lo) * s64'(frac)) / (64'sd1 <<< 33);
    endfunction

    function s64 widen(s64 x);
      return clip(mag(x) << Q_SHIFT, x < 0);
    endfunction

    function u64 narrow(u64 m);
      return (m + (64'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
    endfunction

    function void write_cfg(cfg_reg_e idx, logic [31:0] val);
      if (idx == REG_PRIOR_MEAN) cfg_mean = val;
      else cfg_var = val[30:0];
    endfunction

    function void update_posterior(response_item_t it);
      u64 onef;
      u64 cf;
      u64 df;
      u64 dsc;
      s64 m0, v0, b, ae, a2, s, r, z, p, pm, ph, tq, c, d, aa, w, g, m1, v1;
      u64 az;
      u64 sm;
      u64 mm;
      int k;
      logic signed [31:0] sb;
      onef = 64'd1 << FRAC_BITS;
      cf   = u64'(it.lower_asym);
      df   = u64'(it.upper_asym);
      dsc  = u64'(it.scaling);
      sb   = it.difficulty;
      m0   = widen(post_mean);
      v0   = widen(s64'(post_var));
      b    = widen(s64'(sb));
      if (dsc == 0) dsc = 1;
      if (cf > onef) cf = onef;
      if (df > onef) df = onef;
      ae = div_q(widen(s64'(it.discrimination)), widen(s64'(dsc)));
      a2 = mul_q(ae, ae);
      if (a2 == 0) return;
      s = add_sat(div_q(ONE_Q30, a2), v0);
      if (s < 1) s = 1;
      k = 15;
      while (k > 0 && (u64'(s) >> (62 - 2 * k)) != 0) k--;
      r  = s64'(int_sqrt(u64'(s) << (2 * k)) << (15 - k));
      z  = div_q(add_sat(b, -m0), r);
      az = mag(z);
      ph = interp(1'b0, az);
      tq = interp(1'b1, az);
      if (z >= 0) begin
        p  = ONE_Q30 - tq;
        pm = tq;
      end else begin
        p  = tq;
        pm = ONE_Q30 - tq;
      end
      if (p < 1) p = 1;
      c  = s64'(cf << Q_SHIFT);
      d  = s64'(df << Q_SHIFT);
      aa = c + mul_q(d - c, pm);
      if (aa < 1) aa = 1;
      w  = it.response ? ONE_Q30 - div_q(ONE_Q30, aa) : ONE_Q30;
      g  = mul_q(div_q(ph, p), w);
      m1 = add_sat(m0, -mul_q(mul_q(v0, div_q(ONE_Q30, r)), g));
      v1 = add_sat(v0, -mul_q(mul_q(v0, mul_q(v0, div_q(ONE_Q30, s))),
                              mul_q(g, add_sat(g, z))));
      mm = narrow(mag(m1));
      if (m1 < 0) post_mean = mm > 64'h8000_0000 ? -(64'sd1 <<< 31) : -s64'(mm);
      else post_mean = mm > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : s64'(mm);
      sm = v1 < 0 ? 64'd0 : narrow(u64'(v1));
      post_var = sm > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : sm;
    endfunction

    function void note_response(response_item_t it);
      estimate_t e;
      logic signed [31:0] pm32;
      if (it.start_new) begin
        pm32      = cfg_mean;
        post_mean = s64'(pm32);
        post_var  = u64'(cfg_var);
      end
      if (!it.missing) update_posterior(it);
      e.mean     = post_mean[31:0];
      e.variance = post_var[30:0];
      e.std_err  = 31'(int_sqrt(post_var << FRAC_BITS));
      expected_estimates.push_back(e);
    endfunction

    function void check_result(logic [95:0] data);
      estimate_t e;
      if (expected_estimates.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      e = expected_estimates.pop_front();
      if (data[31:0] !== e.mean) begin
        $display("%0t: ability_mean expected %h actual %h", $time, e.mean, data[31:0]);
        errors++;
      end
      if (data[62:32] !== e.variance) begin
        $display("%0t: ability_variance expected %h actual %h", $time, e.variance,
                 data[62:32]);
        errors++;
      end
      if (data[93:63] !== e.std_err) begin
        $display("%0t: standard_error expected %h actual %h", $time, e.std_err, data[93:63]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_estimates.size();
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic         cfg_addr_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;

  bit                no_idle = 1'b0;
  ability_scoreboard sb = new();

  owen_bayesian_ability_update_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    #(80_000_000);
    $display("owen_bayesian_ability_update_core verification failed");
    $finish;
  end

  task automatic send_response(response_item_t it);
    int gap;
    gap = (!no_idle && $urandom_range(99) < 32) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {7'd0, it.response, it.upper_asym, it.lower_asym, it.scaling,
                      it.discrimination, it.difficulty};
    s_axis_tuser  <= {it.missing, it.start_new};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_response(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  task automatic write_prior(logic [31:0] mean, logic [31:0] variance);
    drain();
    repeat (60) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_PRIOR_MEAN;
    cfg_wdata_i <= mean;
    @(posedge clk_i);
    sb.write_cfg(REG_PRIOR_MEAN, mean);
    @(negedge clk_i);
    cfg_addr_i  <= REG_PRIOR_VAR;
    cfg_wdata_i <= variance;
    @(posedge clk_i);
    sb.write_cfg(REG_PRIOR_VAR, variance);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic response_item_t typical_item();
    response_item_t it;
    it.start_new      = ($urandom_range(11) == 0);
    it.missing        = ($urandom_range(9) == 0);
    it.difficulty     = 32'($signed($urandom_range(393216)) - 196608);
    it.discrimination = 31'($urandom_range(163840, 19661));
    it.scaling        = $urandom_range(1) ? 31'd65536 : 31'd111543;
    it.lower_asym     = 17'($urandom_range(19661));
    it.upper_asym     = 17'($urandom_range(65536, 52429));
    it.response       = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic response_item_t noise_item();
    response_item_t it;
    it.start_new      = 1'($urandom_range(1));
    it.missing        = ($urandom_range(3) == 0);
    it.difficulty     = $urandom;
    it.discrimination = 31'($urandom);
    it.scaling        = 31'($urandom);
    it.lower_asym     = 17'($urandom);
    it.upper_asym     = 17'($urandom);
    it.response       = 1'($urandom_range(1));
    return it;
  endfunction

  initial begin
    response_item_t it;
    logic [31:0]    pmeans[5];
    logic [31:0]    pvars[5];
    pmeans = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_8000, 32'd0, 32'h0001_4000};
    pvars  = '{32'h7FFF_FFFF, 32'd0, 32'd32768, 32'd262144, 32'hFFFF_FFFF};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes and corner cases under reset prior
    it = typical_item();
    it.start_new = 1'b0;
    it.missing   = 1'b0;
    send_response(it);
    it.start_new = 1'b1;
    send_response(it);
    it.start_new = 1'b0;
    it.difficulty = 32'h7FFF_FFFF;
    send_response(it);
    it.difficulty = 32'h8000_0000;
    it.response = 1'b0;
    send_response(it);
    it.difficulty = 32'd0;
    it.discrimination = 31'd0;
    send_response(it);
    it.discrimination = 31'h7FFF_FFFF;
    send_response(it);
    it.discrimination = 31'd65536;
    it.scaling = 31'd0;
    send_response(it);
    it.scaling = 31'h7FFF_FFFF;
    send_response(it);
    it.scaling = 31'd65536;
    it.lower_asym = 17'h1FFFF;
    it.upper_asym = 17'h1FFFF;
    it.response = 1'b1;
    send_response(it);
    it.lower_asym = 17'd0;
    it.upper_asym = 17'd0;
    send_response(it);
    it.lower_asym = 17'd60000;
    it.upper_asym = 17'd10000;
    send_response(it);
    it.response = 1'b0;
    send_response(it);
    it.missing = 1'b1;
    send_response(it);
    it.start_new = 1'b1;
    send_response(it);
    it.start_new = 1'b0;
    it.missing = 1'b0;
    it.lower_asym = 17'd65536;
    it.upper_asym = 17'd65536;
    it.difficulty = 32'h0008_0000;
    send_response(it);
    it.difficulty = 32'hFFF8_0000;
    it.response = 1'b1;
    send_response(it);

    // hold off until the block has returned everything
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_prior(pmeans[ph], pvars[ph]);
      for (int n = 0; n < 200; n++) begin
        no_idle = (ph == 2 && n >= 50 && n < 150);
        it = ($urandom_range(99) < 80) ? typical_item() : noise_item();
        if (n == 0) it.start_new = 1'b1;
        send_response(it);
      end
      no_idle = 1'b0;
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("owen_bayesian_ability_update_core verification clean");
    end else begin
      $display("owen_bayesian_ability_update_core verification failed");
    end
    $finish;
  end

endmodule
